/* rtl/fpc_pkg.sv */
// Shared types, constants and divide-by-255 helpers for the frame pixel compositor.
`default_nettype none

package fpc_pkg;

    // Dimension limit and field widths
    localparam int FPC_MAX_DIM = 4096;
    localparam int COORD_W     = 12;
    localparam int DIM_W       = 13;
    localparam int CH_W        = 8;
    localparam int INDEX_W     = 24;
    localparam int PROD_W      = 2 * DIM_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int MODE_W      = 2;

    // Compose modes
    localparam logic [MODE_W-1:0] MODE_SRC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OVER  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_W = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_H = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_L  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_T  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_W  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_H  = 3'd6;

    // How a written pixel gets its value
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_SRC   = 2'd0;
    localparam kind_t KIND_DST   = 2'd1;
    localparam kind_t KIND_BLEND = 2'd2;
    localparam kind_t KIND_CLEAR = 2'd3;

    // Pipeline shape
    localparam int GEOM_LAT   = 3;
    localparam int BLEND_LAT  = 5;
    localparam int DIV_BPS    = 3;
    localparam int DIV_STAGES = 6;
    localparam int DIV_W      = DIV_BPS * DIV_STAGES;
    localparam int NUM_W      = 17;
    localparam int PIPE_LAT   = BLEND_LAT + DIV_STAGES;
    localparam int SIDE_DLY   = PIPE_LAT - GEOM_LAT;

    // Channel order: 0 red, 1 green, 2 blue, 3 alpha
    typedef logic [3:0][CH_W-1:0] pixel_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DIM_W-1:0]  canvas_width;
        logic [DIM_W-1:0]  canvas_height;
        logic [COORD_W-1:0] frame_left;
        logic [COORD_W-1:0] frame_top;
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
    } cfg_t;

    typedef struct packed {
        logic               we;
        kind_t              kind;
        logic [INDEX_W-1:0] pixel_index;
        pixel_t             pass;
    } side_t;

    // First guess of x/255 for x < 2^24; low by at most one
    function automatic logic [16:0] div255_est(input logic [23:0] x);
        logic [24:0] acc;
        acc = 25'(x) + 25'(x >> 8) + 25'(x >> 16);
        return acc[24:8];
    endfunction

    // Correct the guess with one compare against the remainder
    function automatic logic [16:0] div255_fix(input logic [23:0] x, input logic [16:0] est);
        logic [24:0] prod;
        logic [24:0] rem;
        prod = {est, 8'h00} - 25'(est);
        rem  = 25'(x) - prod;
        return (rem >= 25'd255) ? est + 17'd1 : est;
    endfunction

endpackage

`default_nettype wire

/* rtl/fpc_geom.sv */
// Placement pipeline: clipping, mode decode and canvas index of each pixel.
`default_nettype none

module fpc_geom
    import fpc_pkg::*;
#(
    parameter int MAX_DIM = FPC_MAX_DIM
)
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire cfg_t               cfg,
    input  wire logic [COORD_W-1:0] column,
    input  wire logic [COORD_W-1:0] line,
    input  wire pixel_t             src,
    input  wire pixel_t             dst,
    output side_t                   side
);

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        if (32'(v) > 32'(MAX_DIM))
        begin
            return DIM_W'(MAX_DIM);
        end
        return v;
    endfunction

    logic [DIM_W-1:0] cw_next, ch_next, fw_next, fh_next;
    logic [DIM_W-1:0] cx_next, cy_next;
    logic             we_next;
    kind_t            kind_next;
    pixel_t           pass_next;

    logic             we1_reg, we2_reg;
    kind_t            kind1_reg, kind2_reg;
    pixel_t           pass1_reg, pass2_reg;
    logic [DIM_W-1:0] cx1_reg, cy1_reg, cw1_reg, cx2_reg;
    logic [PROD_W-1:0] prod2_reg;
    side_t            side3_reg;

    // Clip against frame and canvas, decode the mode
    always_comb
    begin
        cw_next   = sat_dim(cfg.canvas_width);
        ch_next   = sat_dim(cfg.canvas_height);
        fw_next   = sat_dim(cfg.frame_width);
        fh_next   = sat_dim(cfg.frame_height);
        cx_next   = {1'b0, column} + {1'b0, cfg.frame_left};
        cy_next   = {1'b0, line} + {1'b0, cfg.frame_top};
        we_next   = ({1'b0, column} < fw_next) && ({1'b0, line} < fh_next)
                    && (cx_next < cw_next) && (cy_next < ch_next);
        kind_next = KIND_CLEAR;
        unique case (cfg.mode)
            MODE_SRC:   kind_next = KIND_SRC;
            MODE_OVER:
            begin
                if (src[3] == 8'hFF)
                begin
                    kind_next = KIND_SRC;
                end
                else if (src[3] == 8'h00)
                begin
                    kind_next = KIND_DST;
                end
                else
                begin
                    kind_next = KIND_BLEND;
                end
            end
            MODE_CLEAR: kind_next = KIND_CLEAR;
            default:    we_next = 1'b0;
        endcase
        pass_next = (kind_next == KIND_DST) ? dst : src;
    end

    // Stage 1: clip result and coordinates
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            we1_reg   <= we_next;
            kind1_reg <= kind_next;
            pass1_reg <= pass_next;
            cx1_reg   <= cx_next;
            cy1_reg   <= cy_next;
            cw1_reg   <= cw_next;
        end
    end

    // Stage 2: row offset product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            we2_reg   <= we1_reg;
            kind2_reg <= kind1_reg;
            pass2_reg <= pass1_reg;
            cx2_reg   <= cx1_reg;
            prod2_reg <= PROD_W'(cy1_reg) * PROD_W'(cw1_reg);
        end
    end

    // Stage 3: add the column and keep the low index bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg.we          <= we2_reg;
            side3_reg.kind        <= kind2_reg;
            side3_reg.pass        <= pass2_reg;
            side3_reg.pixel_index <= prod2_reg[INDEX_W-1:0] + INDEX_W'(cx2_reg);
        end
    end

    assign side = side3_reg;

endmodule

`default_nettype wire

/* rtl/fpc_blend.sv */
// Blend front end: channel products, exact divide by 255, numerators and output alpha.
`default_nettype none

module fpc_blend
    import fpc_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire pixel_t                     src,
    input  wire pixel_t                     dst,
    output logic [2:0][NUM_W-1:0]           num,
    output logic [CH_W-1:0]                 oa
);

    logic [2:0][15:0] sv1_reg, pd1_reg, sv2_reg, sv3_reg, sv4_reg;
    logic [15:0]      fn1_reg;
    logic [CH_W-1:0]  t1_reg, sa1_reg, sa2_reg, sa3_reg, sa4_reg;
    logic [3:0][23:0] x2_reg, x3_reg;
    logic [3:0][16:0] est3_reg;
    logic [3:0][15:0] q4_reg;
    logic [2:0][NUM_W-1:0] num5_reg;
    logic [CH_W-1:0]  oa5_reg;

    logic [CH_W-1:0]  t_next;
    logic [3:0][23:0] x_next;
    logic [3:0][16:0] est_next;
    logic [3:0][15:0] q_next;

    assign t_next = 8'hFF - src[3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            x_next[k] = 24'(pd1_reg[k]) * 24'(t1_reg);
        end
        x_next[3] = 24'(fn1_reg);
        for (int k = 0; k < 4; k++)
        begin
            est_next[k] = div255_est(x2_reg[k]);
            q_next[k]   = 16'(div255_fix(x3_reg[k], est3_reg[k]));
        end
    end

    // Stage 1: source and canvas products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sv1_reg[k] <= 16'(src[k]) * 16'(src[3]);
                pd1_reg[k] <= 16'(dst[k]) * 16'(dst[3]);
            end
            fn1_reg <= 16'(dst[3]) * 16'(t_next);
            t1_reg  <= t_next;
            sa1_reg <= src[3];
        end
    end

    // Stages 2 to 4: weight by (255 - sa), then divide by 255
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg   <= x_next;
            sv2_reg  <= sv1_reg;
            sa2_reg  <= sa1_reg;
            est3_reg <= est_next;
            x3_reg   <= x2_reg;
            sv3_reg  <= sv2_reg;
            sa3_reg  <= sa2_reg;
            q4_reg   <= q_next;
            sv4_reg  <= sv3_reg;
            sa4_reg  <= sa3_reg;
        end
    end

    // Stage 5: blend numerators and output alpha
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                num5_reg[k] <= NUM_W'(sv4_reg[k]) + NUM_W'(q4_reg[k]);
            end
            oa5_reg <= sa4_reg + q4_reg[3][CH_W-1:0];
        end
    end

    assign num = num5_reg;
    assign oa  = oa5_reg;

endmodule

`default_nettype wire

/* rtl/fpc_divider.sv */
// Pipelined restoring divider: three numerators over one shared 8-bit divisor.
`default_nettype none

module fpc_divider
    import fpc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic [2:0][NUM_W-1:0]  num,
    input  wire logic [CH_W-1:0]        den,
    output logic [2:0][CH_W-1:0]        quot,
    output logic [CH_W-1:0]             den_out
);

    logic [2:0][DIV_W-1:0] num_reg [DIV_STAGES];
    logic [2:0][DIV_W-1:0] q_reg   [DIV_STAGES];
    logic [2:0][CH_W-1:0]  rem_reg [DIV_STAGES];
    logic [CH_W-1:0]       den_reg [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_stage
        logic [2:0][DIV_W-1:0] num_in, q_in, num_next, q_next;
        logic [2:0][CH_W-1:0]  rem_in, rem_next;
        logic [CH_W-1:0]       den_in;
        logic [CH_W:0]         trial;

        if (j == 0)
        begin : g_first
            for (genvar k = 0; k < 3; k++)
            begin : g_lane
                assign num_in[k] = DIV_W'(num[k]);
            end
            assign q_in   = '0;
            assign rem_in = '0;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign num_in = num_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
        end

        // Retire DIV_BPS quotient bits per lane, most significant first
        always_comb
        begin
            num_next = num_in;
            q_next   = q_in;
            rem_next = rem_in;
            trial    = '0;
            for (int k = 0; k < 3; k++)
            begin
                for (int b = 0; b < DIV_BPS; b++)
                begin
                    trial       = {rem_next[k], num_next[k][DIV_W-1]};
                    num_next[k] = {num_next[k][DIV_W-2:0], 1'b0};
                    if (trial >= {1'b0, den_in})
                    begin
                        rem_next[k] = CH_W'(trial - {1'b0, den_in});
                        q_next[k]   = {q_next[k][DIV_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[k] = trial[CH_W-1:0];
                        q_next[k]   = {q_next[k][DIV_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[j] <= num_next;
                q_reg[j]   <= q_next;
                rem_reg[j] <= rem_next;
                den_reg[j] <= den_in;
            end
        end
    end

    // Keep the low 8 bits of each quotient
    for (genvar k = 0; k < 3; k++)
    begin : g_out
        assign quot[k] = q_reg[DIV_STAGES-1][k][CH_W-1:0];
    end
    assign den_out = den_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

/* rtl/frame_pixel_compositor.sv */
// Top level of the frame pixel compositor: configuration, pipeline control and output stage.
//
// The compositor takes one frame pixel per clock unless stalled and returns one
// canvas write per pixel, in input order. The rate is
// set by the pipeline: every stage advances together whenever the output
// register is empty or being taken, so with out_ready held high a new pixel is
// accepted every cycle. The deepest part is the straight-alpha divide, a
// restoring divider of six stages that retires three quotient bits per stage.
// Pixels outside the frame or canvas, and the unused mode, give a result with
// write_enable and all other fields at zero. Configuration writes take effect
// at once and must only happen while no pixel is in flight.
`default_nettype none

module frame_pixel_compositor
    import fpc_pkg::*;
#(
    parameter int MAX_DIM = FPC_MAX_DIM
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [COORD_W-1:0]    column,
    input  wire logic [COORD_W-1:0]    line,
    input  wire logic [CH_W-1:0]       src_red,
    input  wire logic [CH_W-1:0]       src_green,
    input  wire logic [CH_W-1:0]       src_blue,
    input  wire logic [CH_W-1:0]       src_alpha,
    input  wire logic [CH_W-1:0]       dst_red,
    input  wire logic [CH_W-1:0]       dst_green,
    input  wire logic [CH_W-1:0]       dst_blue,
    input  wire logic [CH_W-1:0]       dst_alpha,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       write_enable,
    output logic [INDEX_W-1:0]         pixel_index,
    output logic [CH_W-1:0]            out_red,
    output logic [CH_W-1:0]            out_green,
    output logic [CH_W-1:0]            out_blue,
    output logic [CH_W-1:0]            out_alpha
);

    cfg_t                  cfg_reg;
    logic                  en;
    pixel_t                src, dst;
    side_t                 side_geom;
    side_t                 side_dly_reg [SIDE_DLY];
    side_t                 side_end;
    logic [PIPE_LAT-1:0]   valid_reg;
    logic [2:0][NUM_W-1:0] num;
    logic [CH_W-1:0]       oa;
    logic [2:0][CH_W-1:0]  quot;
    logic [CH_W-1:0]       oa_end;

    logic                  out_valid_reg;
    logic                  we_reg, we_next;
    logic [INDEX_W-1:0]    index_reg, index_next;
    pixel_t                pix_reg, pix_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= MODE_SRC;
            cfg_reg.canvas_width  <= DIM_W'(4096);
            cfg_reg.canvas_height <= DIM_W'(4096);
            cfg_reg.frame_left    <= '0;
            cfg_reg.frame_top     <= '0;
            cfg_reg.frame_width   <= DIM_W'(4096);
            cfg_reg.frame_height  <= DIM_W'(4096);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MODE:     cfg_reg.mode          <= cfg_wdata[MODE_W-1:0];
                REG_CANVAS_W: cfg_reg.canvas_width  <= cfg_wdata[DIM_W-1:0];
                REG_CANVAS_H: cfg_reg.canvas_height <= cfg_wdata[DIM_W-1:0];
                REG_FRAME_L:  cfg_reg.frame_left    <= cfg_wdata[COORD_W-1:0];
                REG_FRAME_T:  cfg_reg.frame_top     <= cfg_wdata[COORD_W-1:0];
                REG_FRAME_W:  cfg_reg.frame_width   <= cfg_wdata[DIM_W-1:0];
                REG_FRAME_H:  cfg_reg.frame_height  <= cfg_wdata[DIM_W-1:0];
                default:      ;
            endcase
        end
    end

    // Advance all stages unless the output holds an untaken result
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign src = {src_alpha, src_blue, src_green, src_red};
    assign dst = {dst_alpha, dst_blue, dst_green, dst_red};

    fpc_geom #(
        .MAX_DIM (MAX_DIM)
    ) u_geom (
        .clk    (clk),
        .en     (en),
        .cfg    (cfg_reg),
        .column (column),
        .line   (line),
        .src    (src),
        .dst    (dst),
        .side   (side_geom)
    );

    fpc_blend u_blend (
        .clk (clk),
        .en  (en),
        .src (src),
        .dst (dst),
        .num (num),
        .oa  (oa)
    );

    fpc_divider u_divider (
        .clk     (clk),
        .en      (en),
        .num     (num),
        .den     (oa),
        .quot    (quot),
        .den_out (oa_end)
    );

    // Carry valid bits alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE_LAT-2:0], in_valid};
        end
    end

    // Delay placement results to meet the divider output
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dly_reg[0] <= side_geom;
            for (int i = 1; i < SIDE_DLY; i++)
            begin
                side_dly_reg[i] <= side_dly_reg[i-1];
            end
        end
    end

    assign side_end = side_dly_reg[SIDE_DLY-1];

    // Select the written pixel value
    always_comb
    begin
        we_next    = side_end.we;
        index_next = side_end.we ? side_end.pixel_index : '0;
        pix_next   = '0;
        if (side_end.we)
        begin
            case (side_end.kind) inside
                KIND_SRC, KIND_DST: pix_next = side_end.pass;
                KIND_BLEND:         pix_next = {oa_end, quot[2], quot[1], quot[0]};
                default:            pix_next = '0;
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_reg[PIPE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            we_reg    <= we_next;
            index_reg <= index_next;
            pix_reg   <= pix_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_enable = we_reg;
    assign pixel_index  = index_reg;
    assign out_red      = pix_reg[0];
    assign out_green    = pix_reg[1];
    assign out_blue     = pix_reg[2];
    assign out_alpha    = pix_reg[3];

endmodule

`default_nettype wire
